// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/wpcf_pkg.sv =====
// types, constants and channel table of the weather packet channel filter
// no dependencies
`default_nettype none

package wpcf_pkg;

    localparam int MAX_PACKET_BYTES = 128;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CHANNELS         = 16;
    localparam int CH_W             = 4;
    localparam logic [9:0] SPIKE_RATIO_RST = 10'd154;
    localparam logic [15:0] DASHED_RAW     = 16'h00FF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
        logic       new_window;
    } t_item;

    typedef struct packed {
        logic [3:0]         channel_index;
        logic signed [31:0] channel_total;
        logic signed [23:0] filtered_reading;
        logic               reading_ok;
        logic [15:0]        packets_seen;
        logic               last_channel;
    } t_res;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic eval;
        logic commit;
        logic next_ch;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic end_req;
        logic div_done;
        logic out_taken;
        logic last_ch;
    } t_sts;

    typedef enum logic [2:0] {
        K_INHG, K_TENTHF, K_WHOLEF, K_PLAIN, K_MPH, K_FIFTH
    } t_kind;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic       wide;
        t_kind      kind;
        logic [9:0] limit;
        logic       spiked;
    } t_chan;

    function automatic t_chan chan_desc(input logic [3:0] ch);
        t_chan d;
        unique case (ch)
            4'd0:  d = '{8'd8,  8'd9,  1'b1, K_INHG,   10'd800, 1'b1};
            4'd1:  d = '{8'd10, 8'd11, 1'b1, K_TENTHF, 10'd70,  1'b1};
            4'd2:  d = '{8'd12, 8'd0,  1'b0, K_PLAIN,  10'd100, 1'b1};
            4'd3:  d = '{8'd13, 8'd14, 1'b1, K_TENTHF, 10'd70,  1'b1};
            4'd4:  d = '{8'd15, 8'd0,  1'b0, K_MPH,    10'd100, 1'b1};
            4'd5:  d = '{8'd17, 8'd18, 1'b1, K_PLAIN,  10'd360, 1'b1};
            4'd6:  d = '{8'd31, 8'd32, 1'b1, K_WHOLEF, 10'd70,  1'b1};
            4'd7:  d = '{8'd34, 8'd0,  1'b0, K_PLAIN,  10'd100, 1'b1};
            4'd8:  d = '{8'd36, 8'd37, 1'b1, K_WHOLEF, 10'd70,  1'b0};
            4'd9:  d = '{8'd38, 8'd39, 1'b1, K_WHOLEF, 10'd70,  1'b0};
            4'd10: d = '{8'd40, 8'd41, 1'b1, K_WHOLEF, 10'd70,  1'b0};
            4'd11: d = '{8'd42, 8'd43, 1'b1, K_FIFTH,  10'd100, 1'b1};
            4'd12: d = '{8'd44, 8'd0,  1'b0, K_PLAIN,  10'd100, 1'b0};
            4'd13: d = '{8'd45, 8'd46, 1'b1, K_PLAIN,  10'd70,  1'b0};
            4'd14: d = '{8'd55, 8'd56, 1'b1, K_FIFTH,  10'd100, 1'b1};
            default: d = '{8'd57, 8'd58, 1'b1, K_INHG, 10'd10,  1'b1};
        endcase
        return d;
    endfunction

    // value*256 = (raw - off) * mul / div, fraction reduced
    function automatic logic [19:0] kind_mul(input t_kind k);
        logic [19:0] m;
        unique case (k)
            K_INHG:   m = 20'd4064;
            K_TENTHF: m = 20'd128;
            K_WHOLEF: m = 20'd1280;
            K_MPH:    m = 20'd357632;
            K_FIFTH:  m = 20'd256;
            default:  m = 20'd256;
        endcase
        return m;
    endfunction

    function automatic logic [8:0] kind_off(input t_kind k);
        logic [8:0] o;
        unique case (k)
            K_TENTHF: o = 9'd320;
            K_WHOLEF: o = 9'd32;
            default:  o = 9'd0;
        endcase
        return o;
    endfunction

    function automatic logic [11:0] kind_div(input t_kind k);
        logic [11:0] d;
        unique case (k)
            K_INHG:   d = 12'd625;
            K_TENTHF: d = 12'd9;
            K_WHOLEF: d = 12'd9;
            K_MPH:    d = 12'd3125;
            K_FIFTH:  d = 12'd5;
            default:  d = 12'd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wpcf_div.sv =====
// reciprocal-multiply divider for the fixed conversion denominators
// start registers the operands, then the quotient is registered with done; depends on nothing
`default_nettype none

module wpcf_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [30:0] r_num;
    logic [31:0] r_recip;
    logic [5:0]  r_shift;
    logic [31:0] r_quo;
    logic [31:0] n_recip;
    logic [5:0]  n_shift;
    logic [62:0] n_prod;

    // den = 2 * d, quotient = (num / 2) * ceil(2^s / d) >> s
    always_comb begin
        unique case (i_den)
            16'd10: begin
                n_recip = 32'd1717986919;
                n_shift = 6'd33;
            end
            16'd18: begin
                n_recip = 32'd1908874354;
                n_shift = 6'd34;
            end
            16'd1250: begin
                n_recip = 32'd1759218605;
                n_shift = 6'd40;
            end
            16'd6250: begin
                n_recip = 32'd1407374884;
                n_shift = 6'd42;
            end
            default: begin
                n_recip = 32'd1073741824;
                n_shift = 6'd30;
            end
        endcase
    end

    always_comb begin
        n_prod = 63'(r_num) * 63'(r_recip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= !i_start && r_busy;
            if (i_start) begin
                r_num   <= i_num[31:1];
                r_recip <= n_recip;
                r_shift <= n_shift;
            end else if (r_busy) begin
                r_quo <= 32'(n_prod >> r_shift);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== rtl/wpcf_ctrl.sv =====
// sequencing state machine: byte intake, then per-channel evaluation
// depends on wpcf_pkg
`default_nettype none

module wpcf_ctrl
    import wpcf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_DIV, S_EVAL, S_COMMIT, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = 1'b1;
                if (i_sts.end_req) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.last_ch) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_ch = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wpcf_dp.sv =====
// datapath: byte capture, conversion, spike filter, sums, result register
// depends on wpcf_pkg and wpcf_div
`default_nettype none

module wpcf_dp
    import wpcf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire logic       i_in_valid,
    input  wire t_item      i_in_item,
    input  wire logic       i_cfg_we,
    input  wire logic [9:0] i_cfg_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_res            o_out_res
);

    logic [9:0]         r_ratio;
    logic [POS_W-1:0]   r_pos;
    logic [7:0]         r_latch;
    logic [15:0]        r_raw  [CHANNELS];
    logic signed [23:0] r_prev [CHANNELS];
    logic signed [31:0] r_sum  [CHANNELS];
    logic               r_first;
    logic [15:0]        r_count;
    logic [CH_W-1:0]    r_ch;
    logic               r_neg;
    logic signed [31:0] r_val;
    logic               r_ok;
    logic [32:0]        r_adiff;
    logic signed [34:0] r_prod;
    logic               r_out_valid;
    t_res               r_res;

    logic               n_take;
    logic [15:0]        n_count;
    t_chan              n_d;
    logic [15:0]        n_raw;
    logic signed [31:0] n_base;
    logic signed [52:0] n_scaled;
    logic signed [31:0] n_num;
    logic [15:0]        n_den2;
    logic [31:0]        n_mag;
    logic               div_done;
    logic [31:0]        div_quo;
    logic signed [31:0] n_val;
    logic signed [32:0] n_diff;
    logic               n_hold;
    logic signed [23:0] n_added;
    logic signed [32:0] n_sum;
    logic signed [31:0] n_sat;

    assign n_take = i_cmd.accept && i_in_valid;
    assign n_d    = chan_desc(r_ch);
    assign n_raw  = r_raw[r_ch];

    always_comb begin
        n_count = (r_pos == '0 && i_in_item.new_window) ? 16'd0 : r_count;
        if (i_in_item.packet_end && n_count != 16'hFFFF) n_count = n_count + 16'd1;
    end

    // numerator 2n + d and denominator 2d of the rounded quotient
    always_comb begin
        n_base   = $signed({16'd0, n_raw}) - $signed({23'd0, kind_off(n_d.kind)});
        n_scaled = n_base * $signed({1'b0, kind_mul(n_d.kind)});
        n_num    = $signed({n_scaled[30:0], 1'b0}) + $signed({20'd0, kind_div(n_d.kind)});
        n_den2   = {3'd0, kind_div(n_d.kind), 1'b0};
        n_mag    = n_num[31] ? 32'(-n_num) + {16'd0, n_den2} - 32'd1 : n_num;
    end

    wpcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_mag),
        .i_den   (n_den2),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_val  = r_neg ? -$signed(div_quo) : $signed(div_quo);
        n_diff = $signed({{9{r_prev[r_ch][23]}}, r_prev[r_ch]})
               - $signed({n_val[31], n_val});
    end

    always_comb begin
        n_hold  = n_d.spiked && !r_first
               && !(!r_prod[34] && ({r_adiff, 10'd0} < {9'd0, r_prod[33:0]}));
        n_added = !r_ok ? 24'sd0 : (n_hold ? r_prev[r_ch] : r_val[23:0]);
        n_sum   = $signed({r_sum[r_ch][31], r_sum[r_ch]})
                + $signed({{9{n_added[23]}}, n_added});
        if (n_sum[32] != n_sum[31]) n_sat = n_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else n_sat = n_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= SPIKE_RATIO_RST;
            r_pos       <= '0;
            r_latch     <= '0;
            r_first     <= 1'b1;
            r_count     <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_raw[c]  <= DASHED_RAW;
                r_prev[c] <= '0;
                r_sum[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) r_ratio <= i_cfg_data;
            if (n_take) begin
                if (r_pos == '0 && i_in_item.new_window) begin
                    for (int c = 0; c < CHANNELS; c++) r_sum[c] <= '0;
                end
                r_count <= n_count;
                if (r_pos < POS_W'(MAX_PACKET_BYTES)) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (r_pos == POS_W'(chan_desc(CH_W'(c)).lo)) begin
                            if (chan_desc(CH_W'(c)).wide) r_latch <= i_in_item.data_byte;
                            else r_raw[c] <= {8'd0, i_in_item.data_byte};
                        end
                        if (chan_desc(CH_W'(c)).wide
                            && r_pos == POS_W'(chan_desc(CH_W'(c)).hi)) begin
                            r_raw[c] <= {i_in_item.data_byte, r_latch};
                        end
                    end
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_cmd.div_start) r_neg <= n_num[31];
            if (i_cmd.eval) begin
                r_val   <= n_val;
                r_ok    <= n_raw[7:0] != 8'hFF && n_val <= $signed({14'd0, n_d.limit, 8'd0});
                r_adiff <= n_diff[32] ? 33'(-n_diff) : n_diff;
                r_prod  <= r_prev[r_ch] * $signed({1'b0, r_ratio});
            end
            if (i_cmd.commit) begin
                if (r_ok && n_d.spiked) r_prev[r_ch] <= n_added;
                if (r_ok) r_sum[r_ch] <= n_sat;
                r_out_valid              <= 1'b1;
                r_res.channel_index      <= r_ch;
                r_res.channel_total      <= r_ok ? n_sat : r_sum[r_ch];
                r_res.filtered_reading   <= n_added;
                r_res.reading_ok         <= r_ok;
                r_res.packets_seen       <= r_count;
                r_res.last_channel       <= r_ch == CH_W'(CHANNELS - 1);
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.next_ch) r_ch <= r_ch + CH_W'(1);
            if (i_cmd.finish) begin
                r_ch    <= '0;
                r_pos   <= '0;
                r_first <= 1'b0;
                for (int c = 0; c < CHANNELS; c++) r_raw[c] <= DASHED_RAW;
            end
        end
    end

    assign o_sts.end_req   = n_take && i_in_item.packet_end;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_taken = r_out_valid && i_out_ready;
    assign o_sts.last_ch   = r_ch == CH_W'(CHANNELS - 1);
    assign o_out_valid     = r_out_valid;
    assign o_out_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/weather_packet_channel_filter_top.sv =====
// sequence: after a packet's last byte, each of its results passes through load, divide,
// eval and commit, and the next result starts once the output has taken the last one
// throughput: one byte per cycle inside a packet; no byte taken during the 16 results
// reset: synchronous active low; all channels dashed, sums, previous values and
// packet count zero, spike ratio 154, first packet pending
// top level: joins controller and datapath, depends on wpcf_pkg, wpcf_ctrl and wpcf_dp
`default_nettype none

module weather_packet_channel_filter_top
    import wpcf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_item      i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_res            o_out_res,
    input  wire logic       i_cfg_we,
    input  wire logic [9:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    wpcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wpcf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    assign o_in_ready = cmd.accept;

endmodule

`default_nettype wire

// ===== rtl/wpcf_checker.sv =====
// port-level checks on the weather packet channel filter, bound to the top level
// depends on wpcf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wpcf_checker
    import wpcf_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire t_item      i_in_item,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_res       o_out_res
);

    `ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASSERT_NEXT(a_end_blocks, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_in_item.packet_end, !o_in_ready)
    `ASSERT_NEXT(a_last_frees, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_out_res.last_channel, o_in_ready)
    `ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_res))

endmodule

bind weather_packet_channel_filter_top wpcf_checker u_wpcf_checker (.*);

`default_nettype wire

// ===== bench/tb_weather_packet_channel_filter_top.sv =====
// testbench for weather_packet_channel_filter_top: byte packets in, 16 channel results out
// predicts each result in sv and compares the whole result struct; depends on wpcf_pkg and the rtl
`timescale 1ns / 100ps

module tb_weather_packet_channel_filter_top;
    import wpcf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_item       in_item;
    logic        out_valid;
    logic        out_ready;
    t_res        out_res;
    logic        cfg_we;
    logic [9:0]  cfg_data;

    weather_packet_channel_filter_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int ITEMS        = 410;

    typedef enum int {
        CV_INHG, CV_TENTHF, CV_WHOLEF, CV_PLAIN, CV_MPH, CV_FIFTH
    } t_conv;

    // channel table of the station report
    int    lo_pos  [16] = '{8, 10, 12, 13, 15, 17, 31, 34, 36, 38, 40, 42, 44, 45, 55, 57};
    int    hi_pos  [16] = '{9, 11, 0, 14, 0, 18, 32, 0, 37, 39, 41, 43, 0, 46, 56, 58};
    bit    is_wide [16] = '{1, 1, 0, 1, 0, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1};
    t_conv conv    [16] = '{CV_INHG, CV_TENTHF, CV_PLAIN, CV_TENTHF, CV_MPH, CV_PLAIN,
                            CV_WHOLEF, CV_PLAIN, CV_WHOLEF, CV_WHOLEF, CV_WHOLEF,
                            CV_FIFTH, CV_PLAIN, CV_PLAIN, CV_FIFTH, CV_INHG};
    int    lim     [16] = '{800, 70, 100, 70, 100, 360, 70, 100, 70, 70, 70, 100, 100,
                            70, 100, 10};
    bit    filt    [16] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 0, 0, 1, 1};

    // predictor state
    logic [9:0]   ratio;
    int           pos;
    logic [7:0]   lo_latch;
    logic [15:0]  raw [16];
    longint       prev_val [16];
    longint       sums [16];
    bit           first_pkt;
    int           pkt_count;

    t_res         expected_q[$];
    int           mismatches;
    int           cycles;
    int           sent_items;
    bit           idle_on;
    bit           hold_rx;
    int           hold_len;

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint rdiv(longint n, longint d);
        return fdiv(2 * n + d, 2 * d);
    endfunction

    function automatic longint to_metric(t_conv k, longint r);
        case (k)
            CV_INHG:   return rdiv(r * 254 * 256, 10000);
            CV_TENTHF: return rdiv((r - 320) * 1280, 90);
            CV_WHOLEF: return rdiv((r - 32) * 1280, 9);
            CV_MPH:    return rdiv(r * 1609344 * 256, 3600000);
            CV_FIFTH:  return rdiv(r * 256, 5);
            default:   return r * 256;
        endcase
    endfunction

    task automatic predictor_reset();
        ratio = SPIKE_RATIO_RST;
        pos = 0;
        lo_latch = 0;
        for (int c = 0; c < 16; c++) begin
            raw[c] = DASHED_RAW;
            prev_val[c] = 0;
            sums[c] = 0;
        end
        first_pkt = 1;
        pkt_count = 0;
    endtask

    task automatic predict_byte(t_item it);
        longint v;
        longint added;
        longint p;
        longint d;
        bit ok;
        t_res r;
        if (pos == 0 && it.new_window) begin
            for (int c = 0; c < 16; c++) sums[c] = 0;
            pkt_count = 0;
        end
        if (pos < MAX_PACKET_BYTES) begin
            for (int c = 0; c < 16; c++) begin
                if (pos == lo_pos[c]) begin
                    if (is_wide[c]) lo_latch = it.data_byte;
                    else raw[c] = {8'h00, it.data_byte};
                end
                if (is_wide[c] && pos == hi_pos[c]) raw[c] = {it.data_byte, lo_latch};
            end
            pos++;
        end
        if (!it.packet_end) return;
        if (pkt_count < 65535) pkt_count++;
        for (int c = 0; c < 16; c++) begin
            v = to_metric(conv[c], longint'(raw[c]));
            ok = (raw[c][7:0] != 8'hFF) && (v <= longint'(lim[c]) * 256);
            added = 0;
            if (ok) begin
                added = v;
                if (filt[c]) begin
                    if (!first_pkt) begin
                        p = prev_val[c];
                        d = (p > v) ? p - v : v - p;
                        if (!(d * 1024 < p * longint'(ratio))) added = p;
                    end
                    prev_val[c] = added;
                end
                sums[c] = sums[c] + added;
                if (sums[c] > 64'sd2147483647) sums[c] = 64'sd2147483647;
                if (sums[c] < -64'sd2147483648) sums[c] = -64'sd2147483648;
            end
            r.channel_index = c[3:0];
            r.channel_total = sums[c][31:0];
            r.filtered_reading = added[23:0];
            r.reading_ok = ok;
            r.packets_seen = pkt_count[15:0];
            r.last_channel = (c == 15);
            expected_q.push_back(r);
        end
        pos = 0;
        for (int c = 0; c < 16; c++) raw[c] = DASHED_RAW;
        first_pkt = 0;
    endtask

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge clk) begin
        t_res e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_res);
            end else begin
                e = expected_q.pop_front();
                if (out_res !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch ch %0d: expected %p actual %p",
                                 e.channel_index, e, out_res);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk) begin
        if (hold_rx) begin
            out_ready <= 0;
        end else begin
            out_ready <= !(idle_on && $urandom_range(0, 99) < 10);
        end
    end

    task automatic send_byte(logic [7:0] b, bit last_b, bit clr);
        t_item it;
        while (idle_on && $urandom_range(0, 99) < 10) @(negedge clk);
        it.data_byte = b;
        it.packet_end = last_b;
        it.new_window = clr;
        in_item = it;
        in_valid = 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_byte(it);
        sent_items++;
        @(negedge clk);
        in_valid = 0;
    endtask

    // one packet; mode 0 random bytes, 1 plausible readings, 2 dashed
    task automatic send_packet(int len, bit clr, int mode);
        logic [7:0] b;
        int base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            case (mode)
                1: b = (i % 2) ? 8'h00 : 8'(base + $urandom_range(0, 6));
                2: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1, clr && i == 0);
        end
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_ratio(logic [9:0] v);
        wait_idle();
        cfg_data <= v;
        cfg_we <= 1;
        @(negedge clk);
        cfg_we <= 0;
        ratio = v;
    endtask

    task automatic test_directed();
        send_packet(59, 0, 2);
        send_packet(20, 0, 0);
        send_packet(1, 0, 0);
        idle_on = 0;
        send_packet(130, 1, 1);
        idle_on = 1;
    endtask

    task automatic test_ratio_extremes();
        write_ratio(10'd0);
        send_packet(59, 0, 1);
        write_ratio(10'd1023);
        send_packet(59, 0, 1);
        write_ratio(10'd154);
    endtask

    task automatic test_backpressure();
        hold_rx = 1;
        fork
            begin
                hold_len = 400;
                repeat (hold_len) @(negedge clk);
                hold_rx = 0;
            end
            begin
                send_packet(59, 0, 1);
                send_packet(3, 0, 0);
            end
        join
    endtask

    task automatic test_random();
        int len;
        int mode;
        write_ratio(10'($urandom_range(0, 1023)));
        while (sent_items < ITEMS) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(59, 64)
                                             : $urandom_range(1, 140);
            if (len > ITEMS - sent_items) len = ITEMS - sent_items;
            mode = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 2);
            send_packet(len, $urandom_range(0, 9) == 0, mode);
        end
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        out_ready = 0;
        cfg_we = 0;
        cfg_data = '0;
        cycles = 0;
        sent_items = 0;
        mismatches = 0;
        idle_on = 1;
        hold_rx = 0;
        hold_len = 0;
        predictor_reset();
        repeat (2) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_ratio_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wpcf_pkg.sv
rtl/wpcf_div.sv
rtl/wpcf_ctrl.sv
rtl/wpcf_dp.sv
rtl/weather_packet_channel_filter_top.sv
rtl/wpcf_checker.sv
bench/tb_weather_packet_channel_filter_top.sv
